[rtl/core/linear_predict_coord_reconstruct_unit_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the linear prediction coordinate reconstruct unit.
// Both expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PREDICT_COORD_RECONSTRUCT_UNIT_DEFINES_SVH
`define LINEAR_PREDICT_COORD_RECONSTRUCT_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LPCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPCR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lpcr_pkg.sv]
// ----------------------------------------------------------------------------
// lpcr_pkg
// Types, constants and helpers shared by the coordinate reconstruct unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpcr_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int VALUE_WIDTH = 26;
  localparam int BITS_WIDTH  = 5;
  localparam int COUNT_WIDTH = 12;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(3);

  // register index, taken from paddr[2]
  localparam logic REG_COORD_COUNT = 1'b0;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [BITS_WIDTH-1:0]         x_bits;
    logic [BITS_WIDTH-1:0]         y_bits;
    logic [BITS_WIDTH-1:0]         z_bits;
  } in_word_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] coordinate;
    logic                   last_in_frame;
  } out_word_t;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [COORD_WIDTH-1:0]        mask;
    logic                          predict;
    logic                          last;
  } cmd_t;

  // axis width saturates at COORD_WIDTH, zero width gives an empty mask
  function automatic logic [COORD_WIDTH-1:0] width_mask(input logic [BITS_WIDTH-1:0] bits);
    logic [COORD_WIDTH-1:0] m;
    m = '0;
    for (int i = 0; i < COORD_WIDTH; i++) begin
      m[i] = (32'(bits) > i);
    end
    return m;
  endfunction

endpackage

[rtl/core/lpcr_front.sv]
// ----------------------------------------------------------------------------
// lpcr_front
// Accepts input words, tracks frame position, axis and frame count, and
// hands classified items to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpcr_front import lpcr_pkg::*; #(
  parameter int MAX_COORDS = 3072,
  parameter int IDX_W      = 12,
  parameter int CNT_W      = 12
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  input  logic [COUNT_WIDTH-1:0] coord_count,
  input  logic                   q_full,
  output logic                   q_push,
  output cmd_t                   q_cmd,
  output logic [IDX_W-1:0]       q_idx
);

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  axis_t            axis_r, axis_nxt;
  logic [1:0]       frames_r, frames_nxt;
  logic [CNT_W-1:0] eff_count;
  logic [BITS_WIDTH-1:0] sel_bits;
  logic             last;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (coord_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(coord_count) > MAX_COORDS) begin
      eff_count = CNT_W'(MAX_COORDS);
    end else begin
      eff_count = CNT_W'(coord_count);
    end
  end

  always_comb begin
    unique case (axis_r)
      AXIS_X:  sel_bits = in_data.x_bits;
      AXIS_Y:  sel_bits = in_data.y_bits;
      default: sel_bits = in_data.z_bits;
    endcase
  end

  // a count lowered mid-frame ends the frame at the first position past it
  assign last = (32'(idx_r) + 32'd1) >= 32'(eff_count);

  always_comb begin
    idx_nxt    = idx_r;
    axis_nxt   = axis_r;
    frames_nxt = frames_r;
    if (accept) begin
      if (last) begin
        idx_nxt  = '0;
        axis_nxt = AXIS_X;
        if (frames_r < 2'd2) begin
          frames_nxt = frames_r + 2'd1;
        end
      end else begin
        idx_nxt  = idx_r + IDX_W'(1);
        axis_nxt = (axis_r == AXIS_Z) ? AXIS_X : axis_t'(axis_r + 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      axis_r   <= AXIS_X;
      frames_r <= 2'd0;
    end else begin
      idx_r    <= idx_nxt;
      axis_r   <= axis_nxt;
      frames_r <= frames_nxt;
    end
  end

  assign q_push        = accept;
  assign q_idx         = idx_r;
  assign q_cmd.value   = in_data.value;
  assign q_cmd.mask    = width_mask(sel_bits);
  assign q_cmd.predict = (frames_r >= 2'd2);
  assign q_cmd.last    = last;

endmodule

[rtl/core/lpcr_queue.sv]
// ----------------------------------------------------------------------------
// lpcr_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpcr_queue #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             not_empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/lpcr_back.sv]
// ----------------------------------------------------------------------------
// lpcr_back
// History memory read-modify-write and the output register. Read data is
// registered; a write to the same slot in the same cycle is bypassed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpcr_back import lpcr_pkg::*; #(
  parameter int MAX_COORDS = 3072,
  parameter int IDX_W      = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_not_empty,
  input  cmd_t             q_cmd,
  input  logic [IDX_W-1:0] q_idx,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data
);

  localparam int HW = 2 * COORD_WIDTH;

  // entry is {older, newer}
  logic [HW-1:0]          hist_mem [MAX_COORDS];
  logic [HW-1:0]          hist_r, byp_data_r, hist_sel, wr_data;
  logic                   byp_r;
  logic                   rd_valid_r;
  cmd_t                   rd_cmd_r;
  logic [IDX_W-1:0]       rd_idx_r;
  logic                   out_valid_r;
  out_word_t              out_data_r;
  logic                   adv;
  logic [31:0]            older32, newer32, value32, sum32;
  logic [COORD_WIDTH-1:0] coord;

  assign adv   = rd_valid_r && (!out_valid_r || out_ready);
  assign q_pop = q_not_empty && (!rd_valid_r || adv);

  assign hist_sel = byp_r ? byp_data_r : hist_r;
  assign older32  = 32'(hist_sel[HW-1:COORD_WIDTH]);
  assign newer32  = 32'(hist_sel[COORD_WIDTH-1:0]);
  assign value32  = 32'(rd_cmd_r.value);
  assign sum32    = (newer32 << 1) - older32 + value32;

  assign coord   = (rd_cmd_r.predict ? sum32[COORD_WIDTH-1:0] : value32[COORD_WIDTH-1:0])
                   & rd_cmd_r.mask;
  assign wr_data = {hist_sel[COORD_WIDTH-1:0], coord};

  always_ff @(posedge clk) begin
    if (adv) begin
      hist_mem[rd_idx_r] <= wr_data;
    end
    if (q_pop) begin
      hist_r <= hist_mem[q_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        rd_valid_r <= 1'b1;
        byp_r      <= adv && (rd_idx_r == q_idx);
      end else if (adv) begin
        rd_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_cmd_r   <= q_cmd;
      rd_idx_r   <= q_idx;
      byp_data_r <= wr_data;
    end
    if (adv) begin
      out_data_r.coordinate    <= coord;
      out_data_r.last_in_frame <= rd_cmd_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/core/linear_predict_coord_reconstruct_unit.sv]
// ----------------------------------------------------------------------------
// linear_predict_coord_reconstruct_unit
// Second-order linear prediction decoder for quantized atom coordinates.
//
//   port group   dir   handshake        contents
//   in_*         in    in_valid/ready   value, x_bits, y_bits, z_bits
//   out_*        out   out_valid/ready  coordinate, last_in_frame
//   APB          in    psel/penable     coord_count at offset 0
//
// One word per cycle sustained while out_ready stays high. From input to output
// a word passes the queue, the registered history memory read and the output register.
// A two-entry queue lets the front keep accepting while the output stalls.
// Reset is synchronous; history contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_predict_coord_reconstruct_unit import lpcr_pkg::*; #(
  parameter int MAX_COORDS = 3072
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
  localparam int CNT_W = $clog2(MAX_COORDS + 1);
  localparam int QW    = $bits(cmd_t) + IDX_W;

  logic [COUNT_WIDTH-1:0] coord_count_r;
  logic                   q_full, q_push, q_pop, q_not_empty;
  cmd_t                   push_cmd, pop_cmd;
  logic [IDX_W-1:0]       push_idx, pop_idx;
  logic [QW-1:0]          pop_word;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COORD_COUNT)
                  ? CFG_DATA_W'(coord_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_count_r <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_COORD_COUNT) begin
      coord_count_r <= pwdata[COUNT_WIDTH-1:0];
    end
  end

  lpcr_front #(
    .MAX_COORDS (MAX_COORDS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .coord_count (coord_count_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd),
    .q_idx       (push_idx)
  );

  lpcr_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_cmd, push_idx}),
    .pop       (q_pop),
    .pop_data  (pop_word),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  assign pop_cmd = pop_word[QW-1:IDX_W];
  assign pop_idx = pop_word[IDX_W-1:0];

  lpcr_back #(
    .MAX_COORDS (MAX_COORDS),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_cmd       (pop_cmd),
    .q_idx       (pop_idx),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

[rtl/core/lpcr_checker.sv]
// ----------------------------------------------------------------------------
// lpcr_checker
// Port-level checks on the reconstruct unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_predict_coord_reconstruct_unit_defines.svh"

module lpcr_checker import lpcr_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_word_t             out_data,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [CFG_DATA_W-1:0] pwdata,
  input logic [CFG_DATA_W-1:0] prdata,
  input logic                  pready
);

  // a stalled result word holds
  `LPCR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out word changed while stalled")

  // no result right after reset
  `LPCR_ASSERT_IMP(a_out_reset, $rose(rst_n), !out_valid, "out_valid high after reset")

  // a count write reads back on the next cycle
  `LPCR_ASSERT_IMP(a_cfg_readback, $past(rst_n && psel && penable && pwrite && paddr[2] == REG_COORD_COUNT) && paddr[2] == REG_COORD_COUNT, prdata[COUNT_WIDTH-1:0] == $past(pwdata[COUNT_WIDTH-1:0]), "coord_count readback mismatch")

  // unused register bits read as zero and the port never waits
  `LPCR_ASSERT_IMP(a_cfg_upper, 1'b1, prdata[CFG_DATA_W-1:COUNT_WIDTH] == '0 && pready, "bad upper read bits or pready low")

endmodule

bind linear_predict_coord_reconstruct_unit lpcr_checker u_lpcr_checker (.*);
